FILE: design/sca_pkg.sv
package sca_pkg;

  localparam int unsigned HeadingW   = 3;
  localparam int unsigned Headings   = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned TickW      = 16;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [HeadingW-1:0] CwMaxDiff = 3'd3;

  localparam logic [CfgIndexW-1:0] CFG_MAGNET_THRESHOLD = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LOCKOUT_TICKS    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_TIMEOUT_TICKS    = 2'd2;

  localparam logic [SampleW-1:0] ThresholdReset = 12'd2048;
  localparam logic [TickW-1:0]   LockoutReset   = 16'd200;
  localparam logic [TickW-1:0]   TimeoutReset   = 16'd5000;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [HeadingW-1:0] from_heading;
    logic [HeadingW-1:0] to_heading;
    logic [Headings-1:0] link_mask;
    logic [SampleW-1:0]  sensor_sample;
  } in_item_t;

  typedef struct packed {
    logic              turn_ccw;
    logic [CountW-1:0] stripes_left;
    logic              rotating;
    logic              done_res;
    logic              timed_out;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0] magnet_threshold;
    logic [TickW-1:0]   lockout_ticks;
    logic [TickW-1:0]   timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              ccw;
    logic [CountW-1:0] count;
  } plan_t;

endpackage

FILE: design/sca_cfg_regs.sv
module sca_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sca_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [sca_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output sca_pkg::cfg_t                  cfg_o
);
  import sca_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAGNET_THRESHOLD: cfg_d.magnet_threshold = cfg_wdata_i[SampleW-1:0];
        CFG_LOCKOUT_TICKS:    cfg_d.lockout_ticks    = cfg_wdata_i[TickW-1:0];
        CFG_TIMEOUT_TICKS:    cfg_d.timeout_ticks    = cfg_wdata_i[TickW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magnet_threshold <= ThresholdReset;
      cfg_q.lockout_ticks    <= LockoutReset;
      cfg_q.timeout_ticks    <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/sca_plan.sv
module sca_plan (
  input  logic [sca_pkg::HeadingW-1:0] from_heading_i,
  input  logic [sca_pkg::HeadingW-1:0] to_heading_i,
  input  logic [sca_pkg::Headings-1:0] link_mask_i,
  output sca_pkg::plan_t               plan_o
);
  import sca_pkg::*;

  logic [HeadingW-1:0]   diff;
  logic                  ccw;
  logic [2*Headings-1:0] twice;
  logic [Headings-1:0]   rot;
  logic [Headings-1:0]   sel;
  logic [CountW-1:0]     n;

  // rot[k] is the link bit k steps clockwise from the source heading
  assign diff  = to_heading_i - from_heading_i;
  assign ccw   = diff > CwMaxDiff;
  assign twice = {link_mask_i, link_mask_i} >> from_heading_i;
  assign rot   = twice[Headings-1:0];

  // cw covers steps 0..diff; ccw covers the source plus steps diff..7
  always_comb begin
    n = '0;
    for (int k = 0; k < Headings; k++) begin
      if (ccw) sel[k] = (k == 0) || (HeadingW'(k) >= diff);
      else     sel[k] = HeadingW'(k) <= diff;
      n = n + CountW'(rot[k] & sel[k]);
    end
  end

  assign plan_o.ccw   = ccw;
  assign plan_o.count = n;

endmodule

FILE: design/sca_core.sv
module sca_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sca_pkg::in_item_t  item_i,
  input  sca_pkg::cfg_t      cfg_i,
  output sca_pkg::out_item_t result_o
);
  import sca_pkg::*;

  plan_t             plan;
  logic [CountW-1:0] remaining_q, remaining_d;
  logic              ccw_q, ccw_d;
  logic              disarmed_q, disarmed_d;
  logic [TickW-1:0]  since_q, since_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic              active_q, active_d;
  logic [TickW-1:0]  elapsed_inc, since_inc;
  logic              below;
  logic              done, tmo;

  sca_plan u_plan (
    .from_heading_i (item_i.from_heading),
    .to_heading_i   (item_i.to_heading),
    .link_mask_i    (item_i.link_mask),
    .plan_o         (plan)
  );

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign since_inc   = (since_q == '1) ? since_q : since_q + 1'b1;
  assign below       = item_i.sensor_sample <= cfg_i.magnet_threshold;

  always_comb begin
    remaining_d = remaining_q;
    ccw_d       = ccw_q;
    disarmed_d  = disarmed_q;
    since_d     = since_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    done        = 1'b0;
    tmo         = 1'b0;
    if (item_i.command == CMD_START) begin
      ccw_d       = plan.ccw;
      remaining_d = plan.count;
      disarmed_d  = 1'b0;
      since_d     = '0;
      elapsed_d   = '0;
      active_d    = plan.count != '0;
      done        = plan.count == '0;
    end else if (active_q) begin
      elapsed_d = elapsed_inc;
      since_d   = since_inc;
      if (below && !disarmed_q) begin
        remaining_d = remaining_q - 1'b1;
        disarmed_d  = 1'b1;
        since_d     = '0;
      end else if (!below && disarmed_q && (since_inc > cfg_i.lockout_ticks)) begin
        disarmed_d = 1'b0;
      end
      tmo = elapsed_inc >= cfg_i.timeout_ticks;
      if (remaining_d == '0) begin
        active_d = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      ccw_q       <= 1'b0;
      disarmed_q  <= 1'b0;
      since_q     <= '0;
      elapsed_q   <= '0;
      active_q    <= 1'b0;
    end else if (step_i) begin
      remaining_q <= remaining_d;
      ccw_q       <= ccw_d;
      disarmed_q  <= disarmed_d;
      since_q     <= since_d;
      elapsed_q   <= elapsed_d;
      active_q    <= active_d;
    end
  end

  assign result_o.turn_ccw     = ccw_d;
  assign result_o.stripes_left = remaining_d;
  assign result_o.rotating     = active_d;
  assign result_o.done_res     = done;
  assign result_o.timed_out    = tmo;

endmodule

FILE: design/stripe_counting_rotation_aligner.sv
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+---------------------------
// input     | in_valid_i  | in_stall_o  | in_item_i  (in_item_t)
// result    | out_valid_o | out_stall_i | out_item_o (out_item_t)
// config    | cfg_we_i    | -           | cfg_index_i, cfg_wdata_i
//
// One transaction per cycle sustained while the result is not stalled; a result
// passes from its input transaction through the input register, then the result
// register, before it is on the port.
// The state update and the start-count popcount sit between those registers.
// Reset is asynchronous; it clears the state and both valids and sets the config to its reset values.
// A stalled result holds the input register, which then stalls the input.
module stripe_counting_rotation_aligner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sca_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sca_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [sca_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [sca_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import sca_pkg::*;

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t result;
  out_item_t out_item_q;
  logic      out_valid_q;
  logic      step;
  logic      accept;

  assign step       = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  sca_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sca_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept)    item_valid_q <= 1'b1;
      else if (step) item_valid_q <= 1'b0;
      if (step)             out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (step)   out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: design/sca_checker.sv
module sca_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input sca_pkg::out_item_t             out_item_o
);
  import sca_pkg::*;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_done_not_rotating: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.rotating && out_item_o.done_res))
    else $error("done reported while still rotating");

  a_rotating_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rotating |-> out_item_o.stripes_left != '0)
    else $error("rotating with no stripes left");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.stripes_left <= CountW'(Headings))
    else $error("stripe count out of range");

endmodule

bind stripe_counting_rotation_aligner sca_checker u_sca_checker (.*);

FILE: bench/stripe_counting_rotation_aligner_tb.sv
module stripe_counting_rotation_aligner_tb;
  import sca_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxSample  = (1 << SampleW) - 1;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  stripe_counting_rotation_aligner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [SampleW-1:0] thr_cfg  = ThresholdReset;
  logic [TickW-1:0]   lock_cfg = LockoutReset;
  logic [TickW-1:0]   tmo_cfg  = TimeoutReset;

  // predicted aligner state
  logic              turn_ccw_st  = 1'b0;
  logic [CountW-1:0] left_st      = '0;
  logic              disarmed_st  = 1'b0;
  logic [TickW-1:0]  since_st     = '0;
  logic [TickW-1:0]  elapsed_st   = '0;
  logic              rotating_st  = 1'b0;

  in_item_t  pending_items[$];
  out_item_t expected_status[$];

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 48;
  int unsigned cycle_cnt     = 0;
  int unsigned mismatches    = 0;
  int unsigned accepted_n    = 0;
  int unsigned starts_n      = 0;
  int unsigned hits_n        = 0;
  int unsigned aligned_n     = 0;
  int unsigned timeouts_n    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t rotation_step(input in_item_t it);
    out_item_t         r;
    logic [2:0]        diff;
    logic [2:0]        h;
    logic [CountW-1:0] n;
    r = '0;
    if (it.command == CMD_START) begin
      starts_n++;
      diff        = it.to_heading - it.from_heading;
      turn_ccw_st = diff > CwMaxDiff;
      n           = CountW'(it.link_mask[it.from_heading]);
      h           = it.from_heading;
      while (h != it.to_heading) begin
        h = turn_ccw_st ? h - 3'd1 : h + 3'd1;
        n = n + CountW'(it.link_mask[h]);
      end
      left_st     = n;
      disarmed_st = 1'b0;
      since_st    = '0;
      elapsed_st  = '0;
      rotating_st = (n != 0);
      r.done_res  = (n == 0);
    end else if (rotating_st) begin
      if (elapsed_st != '1) elapsed_st++;
      if (since_st != '1) since_st++;
      if (it.sensor_sample <= thr_cfg && !disarmed_st) begin
        left_st--;
        disarmed_st = 1'b1;
        since_st    = '0;
        hits_n++;
      end else if (it.sensor_sample > thr_cfg && disarmed_st && since_st > lock_cfg) begin
        disarmed_st = 1'b0;
      end
      r.timed_out = (elapsed_st >= tmo_cfg);
      if (left_st == 0) begin
        rotating_st = 1'b0;
        r.done_res  = 1'b1;
      end
    end
    if (r.done_res) aligned_n++;
    if (r.timed_out) timeouts_n++;
    r.turn_ccw     = turn_ccw_st;
    r.stripes_left = left_st;
    r.rotating     = rotating_st;
    return r;
  endfunction

  // driver: a held transaction stays put while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_status.push_back(rotation_step(in_item_i));
        accepted_n++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: %p", out_item_o);
        end else begin
          want = expected_status.pop_front();
          if (out_item_o.turn_ccw !== want.turn_ccw ||
              out_item_o.stripes_left !== want.stripes_left ||
              out_item_o.rotating !== want.rotating ||
              out_item_o.done_res !== want.done_res ||
              out_item_o.timed_out !== want.timed_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status differs at cycle %0d: expected %p, got %p",
                       cycle_cnt, want, out_item_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("stripe_counting_rotation_aligner: mismatch");
    $finish;
  end

  function automatic in_item_t start_item(input logic [2:0] from, input logic [2:0] to,
                                          input logic [7:0] mask);
    in_item_t it;
    it               = in_item_t'($urandom);
    it.command       = CMD_START;
    it.from_heading  = from;
    it.to_heading    = to;
    it.link_mask     = mask;
    return it;
  endfunction

  function automatic in_item_t tick_item(input logic [SampleW-1:0] sample);
    in_item_t it;
    it               = in_item_t'($urandom);
    it.command       = CMD_TICK;
    it.sensor_sample = sample;
    return it;
  endfunction

  function automatic logic [SampleW-1:0] stripe_sample();
    return SampleW'($urandom_range(thr_cfg, 0));
  endfunction

  function automatic logic [SampleW-1:0] floor_sample();
    if (thr_cfg == MaxSample) return SampleW'(MaxSample);
    return SampleW'($urandom_range(MaxSample, thr_cfg + 1));
  endfunction

  // wait until the block has drained everything in flight
  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned thr, input int unsigned lock,
                           input int unsigned tmo);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAGNET_THRESHOLD;
    cfg_wdata_i <= CfgDataW'(thr);
    @(posedge clk_i);
    cfg_index_i <= CFG_LOCKOUT_TICKS;
    cfg_wdata_i <= CfgDataW'(lock);
    @(posedge clk_i);
    cfg_index_i <= CFG_TIMEOUT_TICKS;
    cfg_wdata_i <= CfgDataW'(tmo);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_cfg  = SampleW'(thr);
    lock_cfg = TickW'(lock);
    tmo_cfg  = TickW'(tmo);
    repeat (2) @(posedge clk_i);
  endtask

  // mostly whole rotations with alternating stripe / floor runs, some noise ticks
  task automatic random_rotations(input int unsigned n);
    int unsigned made;
    int unsigned len;
    int unsigned run;
    int unsigned hi_max;
    logic        on_stripe;
    logic [7:0]  mask;
    made   = 0;
    hi_max = (lock_cfg > 10) ? 14 : lock_cfg + 4;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        pending_items.push_back(tick_item(SampleW'($urandom)));
        made++;
      end else begin
        mask = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom);
        pending_items.push_back(start_item(3'($urandom), 3'($urandom), mask));
        made++;
        len       = $urandom_range(40, 4);
        on_stripe = 1'($urandom_range(1));
        while (len > 0 && made < n) begin
          run = on_stripe ? $urandom_range(3, 1) : $urandom_range(hi_max, 1);
          while (run > 0 && len > 0) begin
            pending_items.push_back(tick_item(on_stripe ? stripe_sample() : floor_sample()));
            made++;
            run--;
            len--;
          end
          on_stripe = ~on_stripe;
        end
      end
    end
  endtask

  task automatic random_phase(input int unsigned thr, input int unsigned lock,
                              input int unsigned tmo, input int unsigned n);
    configure(thr, lock, tmo);
    random_rotations(n / 2);
    drain();
    random_rotations(n - n / 2);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, zero count, cw/ccw boundary, restart mid-turn
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(start_item(3'd0, 3'd0, 8'h00));
    pending_items.push_back(start_item(3'd2, 3'd5, 8'hFF));
    pending_items.push_back(tick_item(12'd2048));
    pending_items.push_back(tick_item(12'd2049));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(start_item(3'd5, 3'd1, 8'hFF));
    pending_items.push_back(tick_item(12'hFFF));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(start_item(3'd7, 3'd7, 8'h80));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(start_item(3'd0, 3'd4, 8'h01));

    // zero lockout and timeout: every tick flagged, finish with timeout
    configure(0, 0, 0);
    pending_items.push_back(start_item(3'd1, 3'd3, 8'h0E));
    pending_items.push_back(tick_item(12'd1));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(tick_item(12'd1));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(tick_item(12'hFFF));
    pending_items.push_back(tick_item(12'd0));

    configure(MaxSample, 16'hFFFF, 1);
    pending_items.push_back(start_item(3'd6, 3'd2, 8'hC4));
    pending_items.push_back(tick_item(12'hFFF));
    pending_items.push_back(tick_item(12'hFFF));
    pending_items.push_back(tick_item(12'd0));

    random_phase(2048, 3, 40, 220);
    random_phase($urandom_range(3900, 200), $urandom_range(10), $urandom_range(60, 1), 220);

    send_idle_pct = 48;
    recv_idle_pct = 24;
    random_phase(MaxSample, 0, 16'hFFFF, 220);
    random_phase($urandom_range(3900, 200), $urandom_range(10), $urandom_range(60, 1), 220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(0, 0, 1, 220);
    random_phase($urandom_range(MaxSample), $urandom_range(12), $urandom_range(65535, 20),
                 220);

    // a lockout at max never re-arms, so a second stripe is missed
    configure(2048, 16'hFFFF, 16'hFFFF);
    pending_items.push_back(start_item(3'd0, 3'd1, 8'h03));
    pending_items.push_back(tick_item(12'd0));
    repeat (24) pending_items.push_back(tick_item(floor_sample()));
    pending_items.push_back(tick_item(12'd0));
    pending_items.push_back(start_item(3'd4, 3'd4, 8'h10));
    pending_items.push_back(tick_item(12'd5));

    drain();
    repeat (8) @(posedge clk_i);
    mismatches += expected_status.size();
    $display("run covered %0d transactions: %0d starts, %0d stripe detections,",
             accepted_n, starts_n, hits_n);
    $display("  %0d alignments done, %0d timeout flags, %0d mismatching results",
             aligned_n, timeouts_n, mismatches);
    if (mismatches == 0) begin
      $display("stripe_counting_rotation_aligner: match");
    end else begin
      $display("stripe_counting_rotation_aligner: mismatch");
    end
    $finish;
  end

endmodule
